// ===== sv/bc1d_pkg.sv =====
// bc1d_pkg: shared types and helpers for the bc1 color block decoder
// holds the palette entry types, queue sizing and the 565 widening function
// no dependencies
package bc1d_pkg;

    localparam int unsigned PIXELS      = 16;
    localparam int unsigned PIX_W       = $clog2(PIXELS);
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0] ALPHA_CLEAR  = 8'd0;

    // reciprocal of three in 11 fractional bits, exact for sums up to 765
    localparam logic [10:0] RECIP3 = 11'd683;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_color;

    typedef struct packed {
        t_color [3:0] pal;
        logic [31:0]  index_bits;
    } t_entry;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    function automatic t_rgb widen565(input logic [15:0] c);
        t_rgb o;
        o.r = {c[15:11], c[15:13]};
        o.g = {c[10:5], c[10:9]};
        o.b = {c[4:0], c[4:2]};
        return o;
    endfunction

    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'(RECIP3);
        return p[18:11];
    endfunction

endpackage

// ===== sv/bc1d_front.sv =====
// bc1d_front: classifies a block as three or four color and builds its palette
// depends on bc1d_pkg
module bc1d_front import bc1d_pkg::*; (
    input  logic [15:0] i_endpoint_a,
    input  logic [15:0] i_endpoint_b,
    input  logic [31:0] i_index_bits,
    input  logic        i_punchthrough,
    output t_entry      o_entry
);

    t_rgb       e0;
    t_rgb       e1;
    logic       three;
    logic [7:0] mix2_r, mix2_g, mix2_b;
    logic [7:0] mix3_r, mix3_g, mix3_b;
    logic [8:0] avg_r, avg_g, avg_b;

    assign e0    = widen565(i_endpoint_a);
    assign e1    = widen565(i_endpoint_b);
    assign three = i_punchthrough && (i_endpoint_a <= i_endpoint_b);

    assign avg_r = 9'(e0.r) + 9'(e1.r);
    assign avg_g = 9'(e0.g) + 9'(e1.g);
    assign avg_b = 9'(e0.b) + 9'(e1.b);

    assign mix2_r = div3({1'b0, e0.r, 1'b0} + 10'(e1.r));
    assign mix2_g = div3({1'b0, e0.g, 1'b0} + 10'(e1.g));
    assign mix2_b = div3({1'b0, e0.b, 1'b0} + 10'(e1.b));
    assign mix3_r = div3(10'(e0.r) + {1'b0, e1.r, 1'b0});
    assign mix3_g = div3(10'(e0.g) + {1'b0, e1.g, 1'b0});
    assign mix3_b = div3(10'(e0.b) + {1'b0, e1.b, 1'b0});

    always_comb begin
        o_entry.index_bits = i_index_bits;
        o_entry.pal[0] = '{red: e0.r, green: e0.g, blue: e0.b, alpha: ALPHA_OPAQUE};
        o_entry.pal[1] = '{red: e1.r, green: e1.g, blue: e1.b, alpha: ALPHA_OPAQUE};
        if (three) begin
            o_entry.pal[2] = '{red: avg_r[8:1], green: avg_g[8:1], blue: avg_b[8:1],
                               alpha: ALPHA_OPAQUE};
            o_entry.pal[3] = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: ALPHA_CLEAR};
        end else begin
            o_entry.pal[2] = '{red: mix2_r, green: mix2_g, blue: mix2_b,
                               alpha: ALPHA_OPAQUE};
            o_entry.pal[3] = '{red: mix3_r, green: mix3_g, blue: mix3_b,
                               alpha: ALPHA_OPAQUE};
        end
    end

endmodule

// ===== sv/bc1d_queue.sv =====
// bc1d_queue: short queue of decoded palettes between front and back
// depends on bc1d_pkg
module bc1d_queue import bc1d_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_head,
    output logic   o_full,
    output logic   o_empty
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== sv/bc1d_back.sv =====
// bc1d_back: walks the sixteen indices of the head block and emits one pixel a cycle while the queue is not empty
// depends on bc1d_pkg
module bc1d_back import bc1d_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_entry           i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_pixel_valid,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic [PIX_W-1:0] o_pixel_index,
    output logic             o_last_pixel
);

    logic [PIX_W-1:0] r_cnt, n_cnt;
    logic             r_valid;
    t_color           r_pix;
    logic [PIX_W-1:0] r_pix_idx;
    logic             r_last;
    logic [1:0]       sel;
    logic             last;

    assign sel   = i_head.index_bits[{r_cnt, 1'b0} +: 2];
    assign last  = (r_cnt == PIX_W'(PIXELS - 1));
    assign o_pop = !i_empty && last;
    assign n_cnt = i_empty ? r_cnt : r_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix     <= i_head.pal[sel];
        r_pix_idx <= r_cnt;
        r_last    <= last;
    end

    assign o_pixel_valid = r_valid;
    assign o_red         = r_pix.red;
    assign o_green       = r_pix.green;
    assign o_blue        = r_pix.blue;
    assign o_alpha       = r_pix.alpha;
    assign o_pixel_index = r_pix_idx;
    assign o_last_pixel  = r_last;

endmodule

// ===== sv/bc1_color_block_decoder.sv =====
// bc1_color_block_decoder: top level of the bc1 color block decoder
// depends on bc1d_pkg, bc1d_front, bc1d_queue, bc1d_back
//
// usage:
//   a block (two 565 endpoints and 32 index bits) is taken at a clock edge
//   with start high and busy low. the front builds the four-entry palette in
//   the accepting cycle and writes it into a two-deep queue; busy is high
//   while that queue is full.
//   the back reads the head block and puts out sixteen rgba pixels in raster
//   order, one per cycle, each marked by o_pixel_valid for one cycle, with
//   o_last_pixel on the sixteenth. the receiver cannot stall the output.
//   with the back idle, the block is read straight from the queue head, and
//   each pixel passes through the back's output register. the back emits one
//   pixel per cycle; blocks may be started back to back while earlier ones
//   drain. punchthrough mode is written through the cfg channel (always
//   ready) and resets to 1. reset empties the queue and drops any pending
//   pixels.
module bc1_color_block_decoder import bc1d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_endpoint_a,
    input  logic [15:0] i_endpoint_b,
    input  logic [31:0] i_index_bits,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    output logic        o_pixel_valid,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [3:0]  o_pixel_index,
    output logic        o_last_pixel
);

    logic   r_punch;
    t_entry front_entry;
    t_entry head;
    logic   q_full;
    logic   q_empty;
    logic   pop;
    logic   push;

    assign o_cfg_ready = 1'b1;
    assign busy        = q_full;
    assign push        = start && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_punch <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_punch <= i_cfg_data;
        end
    end

    bc1d_front u_front (
        .i_endpoint_a   (i_endpoint_a),
        .i_endpoint_b   (i_endpoint_b),
        .i_index_bits   (i_index_bits),
        .i_punchthrough (r_punch),
        .o_entry        (front_entry)
    );

    bc1d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    bc1d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_empty       (q_empty),
        .o_pop         (pop),
        .o_pixel_valid (o_pixel_valid),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_alpha       (o_alpha),
        .o_pixel_index (o_pixel_index),
        .o_last_pixel  (o_last_pixel)
    );

endmodule
